FILE: design/swsk_pkg.sv
`default_nettype none
package swsk_pkg;
  localparam int CordicStepsDef = 16;
  localparam int TableLen = 24;
  localparam int InW = 16;
  localparam int AngW = 16;
  localparam int SpdW = 24;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;
  // Corner vector components span 30 bits signed; the CORDIC datapath is 33 bits wide.
  localparam int VecW = 30;
  localparam int CxW = 33;
  localparam int ZW = 34;
  localparam int SqW = 60;
  localparam int RootW = 30;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HALF_TRACK  = 2'd0,
    CFG_AXLE_OFFSET = 2'd1,
    CFG_DEADBAND    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [InW-1:0] lin_speed;
    logic signed [InW-1:0] turn_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [AngW-1:0] angle_front_left;
    logic signed [AngW-1:0] angle_front_right;
    logic signed [AngW-1:0] angle_rear_left;
    logic signed [AngW-1:0] angle_rear_right;
    logic signed [SpdW-1:0] speed_front_left;
    logic signed [SpdW-1:0] speed_front_right;
    logic signed [SpdW-1:0] speed_rear_left;
    logic signed [SpdW-1:0] speed_rear_right;
    logic signed [SpdW-1:0] speed_mid_left;
    logic signed [SpdW-1:0] speed_mid_right;
  } out_item_t;

  typedef struct packed {
    logic                   zero;
    logic signed [VecW-1:0] vxl;
    logic signed [VecW-1:0] vxr;
    logic signed [VecW-1:0] ta;
  } job_t;

  function automatic logic signed [ZW-1:0] atan_fine(input int i);
    logic signed [ZW-1:0] t;
    case (i)
      0: t = 34'sd536870912;
      1: t = 34'sd316933406;
      2: t = 34'sd167458907;
      3: t = 34'sd85004756;
      4: t = 34'sd42667331;
      5: t = 34'sd21354465;
      6: t = 34'sd10679838;
      7: t = 34'sd5340245;
      8: t = 34'sd2670163;
      9: t = 34'sd1335087;
      10: t = 34'sd667544;
      11: t = 34'sd333772;
      12: t = 34'sd166886;
      13: t = 34'sd83443;
      14: t = 34'sd41722;
      15: t = 34'sd20861;
      16: t = 34'sd10430;
      17: t = 34'sd5215;
      18: t = 34'sd2608;
      19: t = 34'sd1304;
      20: t = 34'sd652;
      21: t = 34'sd326;
      22: t = 34'sd163;
      23: t = 34'sd81;
      default: t = '0;
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

FILE: design/swsk_stream_if.sv
`default_nettype none
interface swsk_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/swsk_front.sv
`default_nettype none
module swsk_front (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [swsk_pkg::CfgIdxW-1:0]        cfg_idx,
  input  wire logic [swsk_pkg::CfgDataW-1:0]       cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire swsk_pkg::in_item_t                  in_item,
  output logic                                     job_valid,
  input  wire logic                                job_ready,
  output swsk_pkg::job_t                           job
);
  import swsk_pkg::*;

  logic [15:0] half_track_r;
  logic [15:0] axle_offset_r;
  logic [7:0]  deadband_r;
  logic        s1_valid_r;
  logic        s1_zero_r;
  logic signed [InW-1:0]  s1_v_r;
  logic signed [32:0]     s1_tw_r;
  logic signed [32:0]     s1_ta_r;
  logic        s2_valid_r;
  job_t        s2_job_r;
  logic        adv1;
  logic        adv2;
  logic [16:0] av;
  logic [16:0] aw;
  logic signed [33:0] tw;
  logic signed [33:0] ta;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_track_r  <= 16'd1024;
      axle_offset_r <= 16'd1024;
      deadband_r    <= 8'd4;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_HALF_TRACK:  half_track_r  <= cfg_data;
        CFG_AXLE_OFFSET: axle_offset_r <= cfg_data;
        CFG_DEADBAND:    deadband_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign adv2 = !s2_valid_r || job_ready;
  assign adv1 = !s1_valid_r || adv2;
  assign in_ready = adv1;

  always_comb begin
    av = in_item.lin_speed[InW-1] ? 17'(-$signed({in_item.lin_speed[InW-1], in_item.lin_speed}))
                                  : 17'({1'b0, in_item.lin_speed});
    aw = in_item.turn_rate[InW-1] ? 17'(-$signed({in_item.turn_rate[InW-1], in_item.turn_rate}))
                                  : 17'({1'b0, in_item.turn_rate});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (adv1) s1_valid_r <= in_valid;
      if (adv2) s2_valid_r <= s1_valid_r;
    end
  end

  assign tw = (34'(s1_tw_r) + 34'sd2048) >>> 12;
  assign ta = (34'(s1_ta_r) + 34'sd2048) >>> 12;

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_zero_r <= (av <= 17'(deadband_r)) && (aw <= 17'(deadband_r));
      s1_v_r    <= in_item.lin_speed;
      s1_tw_r   <= 33'(in_item.turn_rate * $signed({1'b0, half_track_r}));
      s1_ta_r   <= 33'(in_item.turn_rate * $signed({1'b0, axle_offset_r}));
    end
    if (adv2 && s1_valid_r) begin
      s2_job_r.zero <= s1_zero_r;
      s2_job_r.vxl  <= VecW'(VecW'(s1_v_r) - VecW'(tw));
      s2_job_r.vxr  <= VecW'(VecW'(s1_v_r) + VecW'(tw));
      s2_job_r.ta   <= VecW'(ta);
    end
  end

  assign job_valid = s2_valid_r;
  assign job = s2_job_r;
endmodule
`default_nettype wire

FILE: design/swsk_fifo.sv
`default_nettype none
module swsk_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_valid,
  output logic                 wr_ready,
  input  wire swsk_pkg::job_t  wr_data,
  output logic                 rd_valid,
  input  wire logic            rd_ready,
  output swsk_pkg::job_t       rd_data
);
  import swsk_pkg::*;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wp_r;
  logic [AW-1:0] rp_r;
  logic [AW:0]   cnt_r;
  logic          wr;
  logic          rd;

  assign wr_ready = cnt_r != (AW+1)'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end
endmodule
`default_nettype wire

FILE: design/swsk_corner.sv
`default_nettype none
module swsk_corner #(
  parameter int CORDIC_STEPS = swsk_pkg::CordicStepsDef
) (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic signed [swsk_pkg::VecW-1:0]   vx,
  input  wire logic signed [swsk_pkg::VecW-1:0]   vy,
  output logic signed [swsk_pkg::AngW-1:0]        angle,
  output logic signed [swsk_pkg::SpdW-1:0]        speed
);
  import swsk_pkg::*;
  localparam int NS = RootW;
  localparam int LAT = (CORDIC_STEPS > NS ? CORDIC_STEPS : NS) + 2;

  logic signed [CxW-1:0] x_r [CORDIC_STEPS+1];
  logic signed [CxW-1:0] y_r [CORDIC_STEPS+1];
  logic signed [ZW-1:0]  z_r [CORDIC_STEPS+1];
  logic signed [ZW-1:0]  zd_r [LAT-CORDIC_STEPS];
  logic [SqW-1:0]   sq_r;
  logic [SqW+1:0]   rn_r [NS+1];
  logic [RootW-1:0] rr_r [NS+1];
  logic [RootW-1:0] rd_r [LAT-NS];
  logic signed [ZW-1:0] zfin;
  logic signed [ZW-1:0] zr;
  logic signed [AngW+1:0] a;
  logic [RootW-1:0] s;
  logic [SpdW-1:0]  smag;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= SqW'(vx * vx) + SqW'(vy * vy);
      if (vx < 0) begin
        x_r[0] <= -CxW'(vx);
        y_r[0] <= -CxW'(vy);
        z_r[0] <= (vy >= 0) ? ZW'(64'sd2147483648) : -ZW'(64'sd2147483648);
      end else begin
        x_r[0] <= CxW'(vx);
        y_r[0] <= CxW'(vy);
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_fine(i);
        end else if (y_r[i] < 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_fine(i);
        end else begin
          x_r[i+1] <= x_r[i];
          y_r[i+1] <= y_r[i];
          z_r[i+1] <= z_r[i];
        end
      end
    end
  end

  // Restoring square root, one result bit per stage.
  always_comb begin
    rn_r[0] = {2'b0, sq_r};
    rr_r[0] = '0;
  end
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    logic [SqW+1:0] rn_q;
    logic [RootW-1:0] rr_q;
    logic [SqW+1:0] trial;
    logic [SqW+1:0] bitv;
    if (k == 0) begin : g_first
      assign rn_q = rn_r[0];
      assign rr_q = rr_r[0];
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en) begin
          rn_q <= rn_r[k];
          rr_q <= rr_r[k];
        end
      end
    end
    assign bitv = (SqW+2)'(1) << (2 * (NS - 1 - k));
    assign trial = ((SqW+2)'(rr_q) << (NS - k)) + bitv;
    always_comb begin
      if (rn_q >= trial) begin
        rn_r[k+1] = rn_q - trial;
        rr_r[k+1] = rr_q | (RootW'(1) << (NS - 1 - k));
      end else begin
        rn_r[k+1] = rn_q;
        rr_r[k+1] = rr_q;
      end
    end
  end

  // Align both paths to LAT stages, the input register included.
  assign zd_r[0] = z_r[CORDIC_STEPS];
  for (genvar d = 1; d < LAT - CORDIC_STEPS; d++) begin : g_zd
    always_ff @(posedge clk) if (en) zd_r[d] <= zd_r[d-1];
  end
  always_ff @(posedge clk) if (en) rd_r[0] <= rr_r[NS];
  for (genvar d = 1; d < LAT - NS; d++) begin : g_rd
    always_ff @(posedge clk) if (en) rd_r[d] <= rd_r[d-1];
  end

  assign zfin = zd_r[LAT-CORDIC_STEPS-1];
  assign s = rd_r[LAT-NS-1];
  assign zr = (zfin + ZW'(32768)) >>> 16;
  assign a = (AngW+2)'(zr);
  assign smag = (s > RootW'(8388607)) ? SpdW'(8388607) : SpdW'(s);

  always_comb begin
    if (a > 18'sd16384) begin
      angle = AngW'(a - 18'sd32768);
      speed = -$signed(smag);
    end else if (a < -18'sd16384) begin
      angle = AngW'(a + 18'sd32768);
      speed = -$signed(smag);
    end else begin
      angle = AngW'(a);
      speed = $signed(smag);
    end
  end
endmodule
`default_nettype wire

FILE: design/swsk_back.sv
`default_nettype none
module swsk_back #(
  parameter int CORDIC_STEPS = swsk_pkg::CordicStepsDef
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 job_valid,
  output logic                      job_ready,
  input  wire swsk_pkg::job_t       job,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output swsk_pkg::out_item_t       res
);
  import swsk_pkg::*;
  localparam int LAT = (CORDIC_STEPS > RootW ? CORDIC_STEPS : RootW) + 3;

  logic                 v_r [LAT];
  job_t                 j_r [LAT];
  logic                 en;
  logic signed [AngW-1:0] ang [4];
  logic signed [SpdW-1:0] spd [4];
  logic signed [VecW-1:0] nta;
  logic signed [SpdW-1:0] ml;
  logic signed [SpdW-1:0] mr;
  job_t jl;

  assign en = !v_r[LAT-1] || res_ready;
  assign job_ready = en;
  assign nta = -job.ta;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= job_valid;
      for (int i = 1; i < LAT; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      j_r[0] <= job;
      for (int i = 1; i < LAT; i++) j_r[i] <= j_r[i-1];
    end
  end

  swsk_corner #(.CORDIC_STEPS(CORDIC_STEPS)) u_fl (.clk, .en, .vx(job.vxl), .vy(job.ta),
    .angle(ang[0]), .speed(spd[0]));
  swsk_corner #(.CORDIC_STEPS(CORDIC_STEPS)) u_fr (.clk, .en, .vx(job.vxr), .vy(job.ta),
    .angle(ang[1]), .speed(spd[1]));
  swsk_corner #(.CORDIC_STEPS(CORDIC_STEPS)) u_rl (.clk, .en, .vx(job.vxl), .vy(nta),
    .angle(ang[2]), .speed(spd[2]));
  swsk_corner #(.CORDIC_STEPS(CORDIC_STEPS)) u_rr (.clk, .en, .vx(job.vxr), .vy(nta),
    .angle(ang[3]), .speed(spd[3]));

  assign jl = j_r[LAT-2];
  assign ml = (jl.vxl > VecW'(8388607)) ? SpdW'(8388607) :
              (jl.vxl < -VecW'(8388608)) ? SpdW'(-24'sd8388608) : SpdW'(jl.vxl);
  assign mr = (jl.vxr > VecW'(8388607)) ? SpdW'(8388607) :
              (jl.vxr < -VecW'(8388608)) ? SpdW'(-24'sd8388608) : SpdW'(jl.vxr);

  out_item_t res_r;
  always_ff @(posedge clk) begin
    if (en) begin
      if (jl.zero) begin
        res_r <= '0;
      end else begin
        res_r.angle_front_left  <= ang[0];
        res_r.angle_front_right <= ang[1];
        res_r.angle_rear_left   <= ang[2];
        res_r.angle_rear_right  <= ang[3];
        res_r.speed_front_left  <= spd[0];
        res_r.speed_front_right <= spd[1];
        res_r.speed_rear_left   <= spd[2];
        res_r.speed_rear_right  <= spd[3];
        res_r.speed_mid_left    <= ml;
        res_r.speed_mid_right   <= mr;
      end
    end
  end

  assign res_valid = v_r[LAT-1];
  assign res = res_r;
  logic unused_j;
  assign unused_j = j_r[LAT-1].zero;
endmodule
`default_nettype wire

FILE: design/six_wheel_steering_kinematics.sv
`default_nettype none
// Six-wheel rover steering: each item (lin_speed, turn_rate) yields one result item with
// four corner angles and speeds and two middle speeds. A new item is taken every cycle;
// items pass two front stages, the queue, and max(CORDIC_STEPS, 30) + 3 back stages, set by
// the 30-stage square-root pipeline that runs beside the CORDIC. The back pipeline halts
// while the result is not taken; the front then fills the queue and stalls the input.
// Configuration writes take effect on the next item.
module six_wheel_steering_kinematics #(
  parameter int CORDIC_STEPS = swsk_pkg::CordicStepsDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [swsk_pkg::CfgIdxW-1:0]  cfg_idx,
  input  wire logic [swsk_pkg::CfgDataW-1:0] cfg_data,
  swsk_stream_if.sink                        in_ch,
  swsk_stream_if.source                      out_ch
);
  import swsk_pkg::*;

  logic f_valid, f_ready, q_valid, q_ready;
  job_t f_job, q_job;

  swsk_front u_front (.clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_ch.data),
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job));

  swsk_fifo #(.DEPTH(2)) u_fifo (.clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready),
    .wr_data(f_job), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job));

  swsk_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (.clk, .rst_n, .job_valid(q_valid),
    .job_ready(q_ready), .job(q_job), .res_valid(out_ch.valid), .res_ready(out_ch.ready),
    .res(out_ch.data));
endmodule
`default_nettype wire

FILE: bench/testbench.sv
module testbench;
  import swsk_pkg::*;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_ALL_ZERO,
    ROW_STRAIGHT
  } row_kind_t;

  typedef struct {
    logic signed [InW-1:0] lin;
    logic signed [InW-1:0] turn;
    row_kind_t             kind;
  } drive_row_t;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 120;
  localparam longint SpeedMax = 8388607;
  localparam longint HalfTurnFine = 64'sd2147483648;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  swsk_stream_if #(.T(in_item_t))  in_ch();
  swsk_stream_if #(.T(out_item_t)) out_ch();

  six_wheel_steering_kinematics i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  logic [15:0] track_half;
  logic [15:0] axle_dist;
  logic [7:0]  dead_zone;

  out_item_t pending_wheels[$];
  int        error_count;
  int        cycle_count;
  int        hold_request;
  int        hold_cycles;
  bit        no_idle;

  longint atan_steps[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned wheel_root(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint steer_heading(longint x, longint y);
    longint z;
    longint xs;
    longint ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? HalfTurnFine : -HalfTurnFine;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CordicStepsDef && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_steps[i];
      end else if (y < 0) begin
        x = x - ys;
        y = y + xs;
        z = z - atan_steps[i];
      end
    end
    return (z + 32768) >>> 16;
  endfunction

  function automatic void steer_corner(input longint vx, input longint vy,
                                       output logic signed [AngW-1:0] ang,
                                       output logic signed [SpdW-1:0] spd);
    longint a;
    longint s;
    s = longint'(wheel_root(longint'(vx * vx) + longint'(vy * vy)));
    a = steer_heading(vx, vy);
    if (s > SpeedMax) s = SpeedMax;
    if (a > 16384) begin
      a = a - 32768;
      s = -s;
    end else if (a < -16384) begin
      a = a + 32768;
      s = -s;
    end
    ang = a[AngW-1:0];
    spd = s[SpdW-1:0];
  endfunction

  function automatic longint clamp_speed(longint x);
    if (x > SpeedMax) return SpeedMax;
    if (x < -SpeedMax - 1) return -SpeedMax - 1;
    return x;
  endfunction

  function automatic out_item_t predict_wheels(in_item_t cmd);
    out_item_t r;
    longint v;
    longint w;
    longint tw;
    longint ta;
    longint vxl;
    longint vxr;
    longint m;
    r = '0;
    v = cmd.lin_speed;
    w = cmd.turn_rate;
    if (!((v < 0 ? -v : v) <= dead_zone && (w < 0 ? -w : w) <= dead_zone)) begin
      tw = (w * longint'(track_half) + 2048) >>> 12;
      ta = (w * longint'(axle_dist) + 2048) >>> 12;
      vxl = v - tw;
      vxr = v + tw;
      steer_corner(vxl, ta, r.angle_front_left, r.speed_front_left);
      steer_corner(vxr, ta, r.angle_front_right, r.speed_front_right);
      steer_corner(vxl, -ta, r.angle_rear_left, r.speed_rear_left);
      steer_corner(vxr, -ta, r.angle_rear_right, r.speed_rear_right);
      m = clamp_speed(vxl);
      r.speed_mid_left = m[SpdW-1:0];
      m = clamp_speed(vxr);
      r.speed_mid_right = m[SpdW-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, field, got,
             want);
    error_count++;
  endtask

  task automatic compare_field(string field, longint got, longint want);
    if (got != want) report_mismatch(field, got, want);
  endtask

  task automatic compare_wheels(out_item_t got, out_item_t want);
    compare_field("angle_front_left", got.angle_front_left, want.angle_front_left);
    compare_field("angle_front_right", got.angle_front_right, want.angle_front_right);
    compare_field("angle_rear_left", got.angle_rear_left, want.angle_rear_left);
    compare_field("angle_rear_right", got.angle_rear_right, want.angle_rear_right);
    compare_field("speed_front_left", got.speed_front_left, want.speed_front_left);
    compare_field("speed_front_right", got.speed_front_right, want.speed_front_right);
    compare_field("speed_rear_left", got.speed_rear_left, want.speed_rear_left);
    compare_field("speed_rear_right", got.speed_rear_right, want.speed_rear_right);
    compare_field("speed_mid_left", got.speed_mid_left, want.speed_mid_left);
    compare_field("speed_mid_right", got.speed_mid_right, want.speed_mid_right);
  endtask

  function automatic int pick_gap();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("testbench failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_cycles = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_wheels.size() == 0) begin
          report_mismatch("unexpected result item", 1, 0);
        end else begin
          compare_wheels(out_ch.data, pending_wheels.pop_front());
        end
      end
      if (hold_request > 0) begin
        hold_cycles = hold_request;
        hold_request = 0;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else if (no_idle) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) < 70) ||
                        (($urandom_range(0, 99) < 50) && pending_wheels.size() > 0);
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HALF_TRACK:  track_half = value;
      CFG_AXLE_OFFSET: axle_dist = value;
      CFG_DEADBAND:    dead_zone = value[7:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_wheels.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic send_command(in_item_t cmd, bit typed, out_item_t want);
    int gap;
    in_ch.data <= cmd;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    pending_wheels.push_back(typed ? want : predict_wheels(cmd));
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic in_item_t random_command();
    in_item_t c;
    int p;
    int span;
    p = $urandom_range(0, 99);
    span = dead_zone + 3;
    c.lin_speed = InW'($urandom());
    c.turn_rate = InW'($urandom());
    if (p < 20) begin
      c.lin_speed = InW'($urandom_range(0, 2 * span) - span);
      c.turn_rate = InW'($urandom_range(0, 2 * span) - span);
    end else if (p < 30) begin
      c.lin_speed = ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
      if ($urandom_range(0, 1) == 1) c.turn_rate = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    end else if (p < 40) begin
      c.turn_rate = '0;
    end else if (p < 50) begin
      c.lin_speed = $urandom_range(0, 1) ? 16'sd0 : c.lin_speed;
      c.turn_rate = $signed(c.turn_rate) >>> $urandom_range(0, 12);
    end
    return c;
  endfunction

  task automatic run_phase(logic [15:0] ht, logic [15:0] ao, logic [7:0] db, int count,
                           bit pressure);
    out_item_t dummy;
    dummy = '0;
    settle();
    write_reg(CFG_HALF_TRACK, ht);
    write_reg(CFG_AXLE_OFFSET, ao);
    write_reg(CFG_DEADBAND, {8'd0, db});
    for (int n = 0; n < count; n++) begin
      if (pressure && n == count / 3) begin
        hold_request = 400;
        no_idle = 1'b1;
      end
      if (pressure && n == count / 3 + 20) no_idle = 1'b0;
      if (pressure && n == 2 * count / 3) begin
        in_ch.valid <= 1'b0;
        while (pending_wheels.size() != 0) @(posedge clk);
      end
      send_command(random_command(), 1'b0, dummy);
    end
  endtask

  drive_row_t opening_rows[] = '{
    '{16'sd0, 16'sd0, ROW_ALL_ZERO},
    '{16'sd4, -16'sd4, ROW_ALL_ZERO},
    '{-16'sd4, 16'sd4, ROW_ALL_ZERO},
    '{16'sd1, -16'sd1, ROW_ALL_ZERO},
    '{16'sd5, 16'sd0, ROW_STRAIGHT},
    '{-16'sd5, 16'sd0, ROW_STRAIGHT},
    '{16'sd1000, 16'sd0, ROW_STRAIGHT},
    '{-16'sd1000, 16'sd0, ROW_STRAIGHT},
    '{16'sh7fff, 16'sd0, ROW_STRAIGHT},
    '{16'sh8000, 16'sd0, ROW_STRAIGHT},
    '{16'sd0, 16'sd5, ROW_PREDICT},
    '{16'sd0, 16'sh7fff, ROW_PREDICT},
    '{16'sd0, 16'sh8000, ROW_PREDICT},
    '{16'sh7fff, 16'sh7fff, ROW_PREDICT},
    '{16'sh8000, 16'sh8000, ROW_PREDICT},
    '{16'sh7fff, 16'sh8000, ROW_PREDICT},
    '{16'sh8000, 16'sh7fff, ROW_PREDICT},
    '{16'sd2048, 16'sd512, ROW_PREDICT},
    '{-16'sd2048, 16'sd512, ROW_PREDICT},
    '{16'sd100, -16'sd3000, ROW_PREDICT},
    '{16'sd16384, -16'sd16384, ROW_PREDICT},
    '{16'sd3, 16'sd4000, ROW_PREDICT}
  };

  initial begin
    in_item_t  cmd;
    out_item_t want;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    error_count = 0;
    cycle_count = 0;
    hold_request = 0;
    no_idle = 1'b0;
    track_half = 16'd1024;
    axle_dist = 16'd1024;
    dead_zone = 8'd4;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_rows[k]) begin
      cmd.lin_speed = opening_rows[k].lin;
      cmd.turn_rate = opening_rows[k].turn;
      want = '0;
      if (opening_rows[k].kind == ROW_STRAIGHT) begin
        want.speed_front_left = SpdW'(opening_rows[k].lin);
        want.speed_front_right = SpdW'(opening_rows[k].lin);
        want.speed_rear_left = SpdW'(opening_rows[k].lin);
        want.speed_rear_right = SpdW'(opening_rows[k].lin);
        want.speed_mid_left = SpdW'(opening_rows[k].lin);
        want.speed_mid_right = SpdW'(opening_rows[k].lin);
      end
      send_command(cmd, opening_rows[k].kind != ROW_PREDICT, want);
    end

    run_phase(16'd0, 16'd0, 8'd0, 60, 1'b0);
    run_phase(16'hffff, 16'hffff, 8'hff, 100, 1'b1);
    run_phase(16'($urandom()), 16'($urandom()), 8'($urandom()), 100, 1'b0);
    no_idle = 1'b1;
    run_phase(16'd1024, 16'd1024, 8'd4, 50, 1'b0);
    no_idle = 1'b0;
    run_phase(16'($urandom_range(0, 4096)), 16'($urandom_range(0, 4096)),
              8'($urandom_range(0, 40)), 90, 1'b0);

    settle();
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
